/* rtl/core/ptc_pkg.sv */
package ptc_pkg;

   localparam int COORD_W   = 16;
   localparam int FRAC_BITS = 16;
   localparam int NEAR_W    = 24;
   localparam int DIST_W    = 48;
   localparam int VEC_W     = COORD_W + 1;
   localparam int DOT_W     = 2 * VEC_W + 2;
   localparam int PROD_W    = 2 * DOT_W;
   localparam int WIDE_W    = PROD_W + 1;
   localparam int CMP_W     = DOT_W + 4;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [VEC_W-1:0]   vec_type;
   typedef logic signed [DOT_W-1:0]   dot_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;
   typedef logic [WIDE_W-1:0]         rem_type;
   typedef logic [FRAC_BITS-1:0]      quo_type;
   typedef logic [FRAC_BITS:0]        frac_type;

   localparam frac_type FRAC_ONE = frac_type'(1) << FRAC_BITS;

   typedef enum logic [2:0] {
      FEAT_FACE    = 3'd0,
      FEAT_VERT_A  = 3'd1,
      FEAT_VERT_B  = 3'd2,
      FEAT_VERT_C  = 3'd3,
      FEAT_EDGE_AB = 3'd4,
      FEAT_EDGE_BC = 3'd5,
      FEAT_EDGE_CA = 3'd6
   } feat_type;

   // how a parameter s or t is formed from the divider lanes
   typedef enum logic [1:0] {
      FSEL_ZERO = 2'd0,
      FSEL_ONE  = 2'd1,
      FSEL_QUO  = 2'd2,
      FSEL_INV  = 2'd3
   } frac_sel_type;

   typedef enum logic [1:0] {
      LMODE_ZERO = 2'd0,
      LMODE_ONE  = 2'd1,
      LMODE_DIV  = 2'd2
   } lane_mode_type;

   typedef struct packed {
      coord_type [2:0] a;
      coord_type [2:0] p;
      vec_type   [2:0] e0;
      vec_type   [2:0] e1;
   } geom_type;

   typedef struct packed {
      feat_type      code;
      logic          bad;
      frac_sel_type  s_sel;
      frac_sel_type  t_sel;
      lane_mode_type mode0;
      lane_mode_type mode1;
      geom_type      geom;
   } side_type;

   typedef struct packed {
      rem_type rem;
      rem_type den;
      quo_type quo;
   } lane_type;

   typedef struct packed {
      feat_type                  code;
      logic [2:0][NEAR_W-1:0]    near;
      logic [DIST_W-1:0]         dist_sq;
      logic                      bad;
   } res_type;

   function automatic dot_type dot3(vec_type [2:0] u, vec_type [2:0] v);
      dot_type acc;
      acc = '0;
      for (int i = 0; i < 3; i++) begin
         acc = acc + dot_type'(u[i]) * dot_type'(v[i]);
      end
      return acc;
   endfunction

endpackage

/* rtl/core/ptc_front.sv */
module ptc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  ptc_pkg::coord_type [11:0]       in_coord,
   output logic                            out_valid,
   output ptc_pkg::side_type               out_side,
   output ptc_pkg::lane_type               out_lane0,
   output ptc_pkg::lane_type               out_lane1
);

   localparam int CW = ptc_pkg::CMP_W;
   localparam int LW = ptc_pkg::WIDE_W + 1;

   // stage 1: edge vectors
   logic               f1_v_ff;
   ptc_pkg::geom_type  f1_geom_ff;
   ptc_pkg::vec_type [2:0] f1_d_ff;
   ptc_pkg::geom_type  f1_geom_in;
   ptc_pkg::vec_type [2:0] f1_d_in;

   // stage 2: dot products
   logic               f2_v_ff;
   ptc_pkg::geom_type  f2_geom_ff;
   ptc_pkg::dot_type   f2_a00_ff, f2_a01_ff, f2_a11_ff, f2_b0_ff, f2_b1_ff;

   // stage 3: wide products
   logic               f3_v_ff;
   ptc_pkg::geom_type  f3_geom_ff;
   ptc_pkg::dot_type   f3_a00_ff, f3_a01_ff, f3_a11_ff, f3_b0_ff, f3_b1_ff;
   ptc_pkg::prod_type  f3_m0011_ff, f3_m0101_ff, f3_m01b1_ff, f3_m11b0_ff;
   ptc_pkg::prod_type  f3_m01b0_ff, f3_m00b1_ff;

   // stage 4: determinant and unnormalized s, t
   logic               f4_v_ff;
   ptc_pkg::geom_type  f4_geom_ff;
   ptc_pkg::dot_type   f4_a00_ff, f4_a01_ff, f4_a11_ff, f4_b0_ff, f4_b1_ff;
   ptc_pkg::wide_type  f4_det_ff, f4_ws_ff, f4_wt_ff;
   ptc_pkg::wide_type  det_raw, det_in;

   // stage 5: region classification
   logic               f5_v_ff;
   ptc_pkg::side_type  f5_side_ff;
   ptc_pkg::lane_type  f5_lane0_ff, f5_lane1_ff;
   ptc_pkg::side_type  side_in;
   ptc_pkg::lane_type  lane0_in, lane1_in;

   logic signed [LW-1:0] sum_st, n0, d0, n1, d1;
   logic signed [CW-1:0] b0x, b1x, a00x, a01x, a11x, den2, tmp0, tmp1, tdif;
   logic                 in_tri, ws_neg, wt_neg, use0, use1;
   ptc_pkg::feat_type    code;
   ptc_pkg::frac_sel_type s_sel, t_sel;

   function automatic ptc_pkg::lane_mode_type lane_mode(logic signed [LW-1:0] n,
                                                        logic signed [LW-1:0] d);
      if (n < 0) begin
         return ptc_pkg::LMODE_ZERO;
      end else if (n >= d) begin
         return ptc_pkg::LMODE_ONE;
      end else begin
         return ptc_pkg::LMODE_DIV;
      end
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f1_geom_in.p[i]  = in_coord[i];
         f1_geom_in.a[i]  = in_coord[3+i];
         f1_geom_in.e0[i] = ptc_pkg::vec_type'(in_coord[6+i]) -
                            ptc_pkg::vec_type'(in_coord[3+i]);
         f1_geom_in.e1[i] = ptc_pkg::vec_type'(in_coord[9+i]) -
                            ptc_pkg::vec_type'(in_coord[3+i]);
         f1_d_in[i]       = ptc_pkg::vec_type'(in_coord[3+i]) -
                            ptc_pkg::vec_type'(in_coord[i]);
      end
   end

   assign det_raw = ptc_pkg::wide_type'(f3_m0011_ff) - ptc_pkg::wide_type'(f3_m0101_ff);
   assign det_in  = det_raw[ptc_pkg::WIDE_W-1] ? -det_raw : det_raw;

   always_comb begin
      b0x    = CW'(f4_b0_ff);
      b1x    = CW'(f4_b1_ff);
      a00x   = CW'(f4_a00_ff);
      a01x   = CW'(f4_a01_ff);
      a11x   = CW'(f4_a11_ff);
      den2   = a00x - (a01x <<< 1) + a11x;
      sum_st = LW'(f4_ws_ff) + LW'(f4_wt_ff);
      in_tri = sum_st <= LW'(f4_det_ff);
      ws_neg = f4_ws_ff[ptc_pkg::WIDE_W-1];
      wt_neg = f4_wt_ff[ptc_pkg::WIDE_W-1];
      code   = ptc_pkg::FEAT_FACE;
      s_sel  = ptc_pkg::FSEL_ZERO;
      t_sel  = ptc_pkg::FSEL_ZERO;
      use0   = 1'b0;
      use1   = 1'b0;
      n0     = '0;
      d0     = LW'(1);
      n1     = '0;
      d1     = LW'(1);
      tmp0   = '0;
      tmp1   = '0;
      tdif   = '0;
      priority if (in_tri) begin
         priority if (ws_neg && wt_neg && b0x < 0) begin
            if (-b0x >= a00x) begin
               code = ptc_pkg::FEAT_VERT_B; s_sel = ptc_pkg::FSEL_ONE;
            end else begin
               code = ptc_pkg::FEAT_EDGE_AB; s_sel = ptc_pkg::FSEL_QUO;
               use0 = 1'b1; n0 = LW'(-b0x); d0 = LW'(a00x);
            end
         end else if (ws_neg) begin
            priority if (b1x >= 0) begin
               code = ptc_pkg::FEAT_VERT_A;
            end else if (-b1x >= a11x) begin
               code = ptc_pkg::FEAT_VERT_C; t_sel = ptc_pkg::FSEL_ONE;
            end else begin
               code = ptc_pkg::FEAT_EDGE_CA; t_sel = ptc_pkg::FSEL_QUO;
               use1 = 1'b1; n1 = LW'(-b1x); d1 = LW'(a11x);
            end
         end else if (wt_neg) begin
            priority if (b0x >= 0) begin
               code = ptc_pkg::FEAT_VERT_A;
            end else if (-b0x >= a00x) begin
               code = ptc_pkg::FEAT_VERT_B; s_sel = ptc_pkg::FSEL_ONE;
            end else begin
               code = ptc_pkg::FEAT_EDGE_AB; s_sel = ptc_pkg::FSEL_QUO;
               use0 = 1'b1; n0 = LW'(-b0x); d0 = LW'(a00x);
            end
         end else begin
            code  = ptc_pkg::FEAT_FACE;
            s_sel = ptc_pkg::FSEL_QUO;
            t_sel = ptc_pkg::FSEL_QUO;
            use0  = 1'b1; n0 = LW'(f4_ws_ff); d0 = LW'(f4_det_ff);
            use1  = 1'b1; n1 = LW'(f4_wt_ff); d1 = LW'(f4_det_ff);
         end
      end else if (ws_neg) begin
         tmp0 = a01x + b0x;
         tmp1 = a11x + b1x;
         tdif = tmp1 - tmp0;
         priority if (tmp1 > tmp0) begin
            if (tdif >= den2) begin
               code = ptc_pkg::FEAT_VERT_B; s_sel = ptc_pkg::FSEL_ONE;
            end else begin
               code = ptc_pkg::FEAT_EDGE_BC; s_sel = ptc_pkg::FSEL_QUO;
               t_sel = ptc_pkg::FSEL_INV;
               use0 = 1'b1; n0 = LW'(tdif); d0 = LW'(den2);
            end
         end else if (tmp1 <= 0) begin
            code = ptc_pkg::FEAT_VERT_C; t_sel = ptc_pkg::FSEL_ONE;
         end else if (b1x >= 0) begin
            code = ptc_pkg::FEAT_VERT_A;
         end else begin
            code = ptc_pkg::FEAT_EDGE_CA; t_sel = ptc_pkg::FSEL_QUO;
            use1 = 1'b1; n1 = LW'(-b1x); d1 = LW'(a11x);
         end
      end else if (wt_neg) begin
         tmp0 = a01x + b1x;
         tmp1 = a00x + b0x;
         tdif = tmp1 - tmp0;
         priority if (tmp1 > tmp0) begin
            if (tdif >= den2) begin
               code = ptc_pkg::FEAT_VERT_C; t_sel = ptc_pkg::FSEL_ONE;
            end else begin
               code = ptc_pkg::FEAT_EDGE_BC; t_sel = ptc_pkg::FSEL_QUO;
               s_sel = ptc_pkg::FSEL_INV;
               use1 = 1'b1; n1 = LW'(tdif); d1 = LW'(den2);
            end
         end else if (tmp1 <= 0) begin
            code = ptc_pkg::FEAT_VERT_B; s_sel = ptc_pkg::FSEL_ONE;
         end else if (b0x >= 0) begin
            code = ptc_pkg::FEAT_VERT_A;
         end else begin
            code = ptc_pkg::FEAT_EDGE_AB; s_sel = ptc_pkg::FSEL_QUO;
            use0 = 1'b1; n0 = LW'(-b0x); d0 = LW'(a00x);
         end
      end else begin
         tmp0 = a11x + b1x - a01x - b0x;
         priority if (tmp0 <= 0) begin
            code = ptc_pkg::FEAT_VERT_C; t_sel = ptc_pkg::FSEL_ONE;
         end else if (tmp0 >= den2) begin
            code = ptc_pkg::FEAT_VERT_B; s_sel = ptc_pkg::FSEL_ONE;
         end else begin
            code = ptc_pkg::FEAT_EDGE_BC; s_sel = ptc_pkg::FSEL_QUO;
            t_sel = ptc_pkg::FSEL_INV;
            use0 = 1'b1; n0 = LW'(tmp0); d0 = LW'(den2);
         end
      end

      side_in.code  = code;
      side_in.bad   = (use0 && d0 <= 0) || (use1 && d1 <= 0);
      side_in.s_sel = s_sel;
      side_in.t_sel = t_sel;
      side_in.mode0 = lane_mode(n0, d0);
      side_in.mode1 = lane_mode(n1, d1);
      side_in.geom  = f4_geom_ff;
      lane0_in.rem  = n0[ptc_pkg::WIDE_W-1:0];
      lane0_in.den  = d0[ptc_pkg::WIDE_W-1:0];
      lane0_in.quo  = '0;
      lane1_in.rem  = n1[ptc_pkg::WIDE_W-1:0];
      lane1_in.den  = d1[ptc_pkg::WIDE_W-1:0];
      lane1_in.quo  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
         f3_v_ff <= 1'b0;
         f4_v_ff <= 1'b0;
         f5_v_ff <= 1'b0;
      end else if (en) begin
         f1_v_ff <= in_valid;
         f2_v_ff <= f1_v_ff;
         f3_v_ff <= f2_v_ff;
         f4_v_ff <= f3_v_ff;
         f5_v_ff <= f4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_geom_ff  <= f1_geom_in;
         f1_d_ff     <= f1_d_in;

         f2_geom_ff  <= f1_geom_ff;
         f2_a00_ff   <= ptc_pkg::dot3(f1_geom_ff.e0, f1_geom_ff.e0);
         f2_a01_ff   <= ptc_pkg::dot3(f1_geom_ff.e0, f1_geom_ff.e1);
         f2_a11_ff   <= ptc_pkg::dot3(f1_geom_ff.e1, f1_geom_ff.e1);
         f2_b0_ff    <= ptc_pkg::dot3(f1_d_ff, f1_geom_ff.e0);
         f2_b1_ff    <= ptc_pkg::dot3(f1_d_ff, f1_geom_ff.e1);

         f3_geom_ff  <= f2_geom_ff;
         f3_a00_ff   <= f2_a00_ff;
         f3_a01_ff   <= f2_a01_ff;
         f3_a11_ff   <= f2_a11_ff;
         f3_b0_ff    <= f2_b0_ff;
         f3_b1_ff    <= f2_b1_ff;
         f3_m0011_ff <= ptc_pkg::prod_type'(f2_a00_ff) * ptc_pkg::prod_type'(f2_a11_ff);
         f3_m0101_ff <= ptc_pkg::prod_type'(f2_a01_ff) * ptc_pkg::prod_type'(f2_a01_ff);
         f3_m01b1_ff <= ptc_pkg::prod_type'(f2_a01_ff) * ptc_pkg::prod_type'(f2_b1_ff);
         f3_m11b0_ff <= ptc_pkg::prod_type'(f2_a11_ff) * ptc_pkg::prod_type'(f2_b0_ff);
         f3_m01b0_ff <= ptc_pkg::prod_type'(f2_a01_ff) * ptc_pkg::prod_type'(f2_b0_ff);
         f3_m00b1_ff <= ptc_pkg::prod_type'(f2_a00_ff) * ptc_pkg::prod_type'(f2_b1_ff);

         f4_geom_ff  <= f3_geom_ff;
         f4_a00_ff   <= f3_a00_ff;
         f4_a01_ff   <= f3_a01_ff;
         f4_a11_ff   <= f3_a11_ff;
         f4_b0_ff    <= f3_b0_ff;
         f4_b1_ff    <= f3_b1_ff;
         f4_det_ff   <= det_in;
         f4_ws_ff    <= ptc_pkg::wide_type'(f3_m01b1_ff) - ptc_pkg::wide_type'(f3_m11b0_ff);
         f4_wt_ff    <= ptc_pkg::wide_type'(f3_m01b0_ff) - ptc_pkg::wide_type'(f3_m00b1_ff);

         f5_side_ff  <= side_in;
         f5_lane0_ff <= lane0_in;
         f5_lane1_ff <= lane1_in;
      end
   end

   assign out_valid = f5_v_ff;
   assign out_side  = f5_side_ff;
   assign out_lane0 = f5_lane0_ff;
   assign out_lane1 = f5_lane1_ff;

endmodule

/* rtl/core/ptc_div_step.sv */
module ptc_div_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  ptc_pkg::side_type in_side,
   input  ptc_pkg::lane_type in_lane0,
   input  ptc_pkg::lane_type in_lane1,
   output logic              out_valid,
   output ptc_pkg::side_type out_side,
   output ptc_pkg::lane_type out_lane0,
   output ptc_pkg::lane_type out_lane1
);

   logic              v_ff;
   ptc_pkg::side_type side_ff;
   ptc_pkg::lane_type lane0_ff, lane1_ff;

   // one restoring step: shift, compare, subtract, one quotient bit
   function automatic ptc_pkg::lane_type step(ptc_pkg::lane_type l);
      logic [ptc_pkg::WIDE_W:0] r2;
      logic [ptc_pkg::WIDE_W:0] dx;
      logic                     ge;
      ptc_pkg::lane_type        o;
      r2    = {l.rem, 1'b0};
      dx    = {1'b0, l.den};
      ge    = r2 >= dx;
      r2    = ge ? r2 - dx : r2;
      o.rem = r2[ptc_pkg::WIDE_W-1:0];
      o.den = l.den;
      o.quo = {l.quo[ptc_pkg::FRAC_BITS-2:0], ge};
      return o;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff  <= in_side;
         lane0_ff <= step(in_lane0);
         lane1_ff <= step(in_lane1);
      end
   end

   assign out_valid = v_ff;
   assign out_side  = side_ff;
   assign out_lane0 = lane0_ff;
   assign out_lane1 = lane1_ff;

endmodule

/* rtl/core/ptc_back.sv */
module ptc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  ptc_pkg::side_type in_side,
   input  ptc_pkg::lane_type in_lane0,
   input  ptc_pkg::lane_type in_lane1,
   output logic              out_valid,
   output ptc_pkg::res_type  out_res
);

   localparam int PW = 2 * ptc_pkg::VEC_W + 1;
   localparam int FW = PW + 2;
   localparam int NW = FW - (ptc_pkg::FRAC_BITS - 8);
   localparam int DW = NW + 1;
   localparam int SW = ptc_pkg::DIST_W + 2;

   // stage 1: parameters
   logic                 b1_v_ff;
   ptc_pkg::feat_type    b1_code_ff;
   logic                 b1_bad_ff;
   ptc_pkg::frac_type    b1_s_ff, b1_t_ff;
   ptc_pkg::geom_type    b1_geom_ff;
   ptc_pkg::frac_type    r0, r1, s_in, t_in;

   // stage 2: edge scaling
   logic                 b2_v_ff;
   ptc_pkg::feat_type    b2_code_ff;
   logic                 b2_bad_ff;
   ptc_pkg::coord_type   b2_a_ff [3];
   ptc_pkg::coord_type   b2_p_ff [3];
   logic signed [PW-1:0] b2_pe0_ff [3];
   logic signed [PW-1:0] b2_pe1_ff [3];

   // stage 3: near point and offset
   logic                 b3_v_ff;
   ptc_pkg::feat_type    b3_code_ff;
   logic                 b3_bad_ff;
   logic [2:0][ptc_pkg::NEAR_W-1:0] b3_near_ff;
   logic signed [DW-1:0] b3_diff_ff [3];
   logic signed [FW-1:0] full [3];
   logic signed [NW-1:0] nearv [3];

   // stage 4: squares
   logic                 b4_v_ff;
   ptc_pkg::feat_type    b4_code_ff;
   logic                 b4_bad_ff;
   logic [2:0][ptc_pkg::NEAR_W-1:0] b4_near_ff;
   logic [ptc_pkg::DIST_W-1:0] b4_sq_ff [3];
   logic [2:0]           b4_big_ff;
   logic [DW-1:0]        mag [3];

   logic [SW-1:0]        dist_sum;

   function automatic ptc_pkg::frac_type lane_val(ptc_pkg::lane_mode_type m,
                                                 ptc_pkg::quo_type q);
      ptc_pkg::frac_type v;
      case (m)
         ptc_pkg::LMODE_ONE:  v = ptc_pkg::FRAC_ONE;
         ptc_pkg::LMODE_DIV:  v = ptc_pkg::frac_type'(q);
         default:             v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      r0 = lane_val(in_side.mode0, in_lane0.quo);
      r1 = lane_val(in_side.mode1, in_lane1.quo);
      unique case (in_side.s_sel)
         ptc_pkg::FSEL_ZERO: s_in = '0;
         ptc_pkg::FSEL_ONE:  s_in = ptc_pkg::FRAC_ONE;
         ptc_pkg::FSEL_QUO:  s_in = r0;
         ptc_pkg::FSEL_INV:  s_in = ptc_pkg::FRAC_ONE - r1;
      endcase
      unique case (in_side.t_sel)
         ptc_pkg::FSEL_ZERO: t_in = '0;
         ptc_pkg::FSEL_ONE:  t_in = ptc_pkg::FRAC_ONE;
         ptc_pkg::FSEL_QUO:  t_in = r1;
         ptc_pkg::FSEL_INV:  t_in = ptc_pkg::FRAC_ONE - r0;
      endcase
      // zero or negative divisor falls back to vertex a
      if (in_side.bad) begin
         s_in = '0;
         t_in = '0;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         full[i]  = FW'($signed({b2_a_ff[i], {ptc_pkg::FRAC_BITS{1'b0}}})) +
                    FW'(b2_pe0_ff[i]) + FW'(b2_pe1_ff[i]);
         nearv[i] = full[i][FW-1:ptc_pkg::FRAC_BITS-8];
         mag[i]   = b3_diff_ff[i][DW-1] ? DW'(-b3_diff_ff[i]) : DW'(b3_diff_ff[i]);
      end
   end

   assign dist_sum = SW'(b4_sq_ff[0]) + SW'(b4_sq_ff[1]) + SW'(b4_sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0;
         b2_v_ff <= 1'b0;
         b3_v_ff <= 1'b0;
         b4_v_ff <= 1'b0;
      end else if (en) begin
         b1_v_ff <= in_valid;
         b2_v_ff <= b1_v_ff;
         b3_v_ff <= b2_v_ff;
         b4_v_ff <= b3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_code_ff <= in_side.bad ? ptc_pkg::FEAT_VERT_A : in_side.code;
         b1_bad_ff  <= in_side.bad;
         b1_s_ff    <= s_in;
         b1_t_ff    <= t_in;
         b1_geom_ff <= in_side.geom;

         b2_code_ff <= b1_code_ff;
         b2_bad_ff  <= b1_bad_ff;
         b3_code_ff <= b2_code_ff;
         b3_bad_ff  <= b2_bad_ff;
         b4_code_ff <= b3_code_ff;
         b4_bad_ff  <= b3_bad_ff;
         b4_near_ff <= b3_near_ff;
         for (int i = 0; i < 3; i++) begin
            b2_a_ff[i]    <= b1_geom_ff.a[i];
            b2_p_ff[i]    <= b1_geom_ff.p[i];
            b2_pe0_ff[i]  <= PW'(b1_geom_ff.e0[i]) * PW'($signed({1'b0, b1_s_ff}));
            b2_pe1_ff[i]  <= PW'(b1_geom_ff.e1[i]) * PW'($signed({1'b0, b1_t_ff}));

            b3_near_ff[i] <= nearv[i][ptc_pkg::NEAR_W-1:0];
            b3_diff_ff[i] <= DW'(nearv[i]) - DW'($signed({b2_p_ff[i], 8'h00}));

            b4_big_ff[i]  <= |mag[i][DW-1:ptc_pkg::NEAR_W];
            b4_sq_ff[i]   <= ptc_pkg::DIST_W'(mag[i][ptc_pkg::NEAR_W-1:0]) *
                             ptc_pkg::DIST_W'(mag[i][ptc_pkg::NEAR_W-1:0]);
         end
      end
   end

   always_comb begin
      out_res.code = b4_code_ff;
      out_res.near = b4_near_ff;
      out_res.bad  = b4_bad_ff;
      if ((|b4_big_ff) || (|dist_sum[SW-1:ptc_pkg::DIST_W])) begin
         out_res.dist_sq = '1;
      end else begin
         out_res.dist_sq = dist_sum[ptc_pkg::DIST_W-1:0];
      end
   end

   assign out_valid = b4_v_ff;

endmodule

/* rtl/core/point_triangle_closest_point.sv */
// triangle point closest to a query point, one beat per clock unless stalled
//
// req channel: one beat holds the query point p and the corners a, b, c as
// signed 16-bit coordinates with 4 fraction bits. rsp channel: one beat per
// request, in order, with the feature code and degenerate flag in tuser and
// the nearest point (12 fraction bits) and saturated squared distance
// (24 fraction bits) in tdata.
//
// pipeline: 5 setup stages (edges, dot products, wide products, determinant,
// region test), 16 divider stages that each make one quotient bit of s and
// t in two parallel lanes, and 5 stages for the near point, squares and
// output register. throughput is one beat per cycle while the receiver
// does not stall.
//
// reset clears every valid bit; in-flight beats are dropped. when the
// receiver stalls, one more beat drains into a skid register, then
// req_tready drops and the whole pipeline holds until rsp_tready returns.
module point_triangle_closest_point (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   // query_x, query_y, query_z, corner_a_x/y/z, corner_b_x/y/z, corner_c_x/y/z
   input  logic [191:0]   req_tdata,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   // near_x, near_y, near_z, dist_squared
   output logic [119:0]   rsp_tdata,
   // feature_code, degenerate
   output logic [3:0]     rsp_tuser
);

   localparam int NDIV = ptc_pkg::FRAC_BITS;

   logic                     en;
   ptc_pkg::coord_type [11:0] coord;

   logic                     div_v    [NDIV+1];
   ptc_pkg::side_type        div_side [NDIV+1];
   ptc_pkg::lane_type        div_l0   [NDIV+1];
   ptc_pkg::lane_type        div_l1   [NDIV+1];

   logic                     back_v;
   ptc_pkg::res_type         back_res;

   // output register plus one skid entry
   logic                     out_v_ff, skid_v_ff;
   ptc_pkg::res_type         out_ff, skid_ff;
   logic                     out_take, push;

   // pipeline moves whenever the skid entry is free
   assign en         = !skid_v_ff;
   assign req_tready = en;

   always_comb begin
      for (int i = 0; i < 12; i++) begin
         coord[i] = req_tdata[ptc_pkg::COORD_W*i +: ptc_pkg::COORD_W];
      end
   end

   ptc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_coord  (coord),
      .out_valid (div_v[0]),
      .out_side  (div_side[0]),
      .out_lane0 (div_l0[0]),
      .out_lane1 (div_l1[0])
   );

   // one quotient bit per stage, msb first
   for (genvar k = 0; k < NDIV; k++) begin : g_div
      ptc_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (div_v[k]),
         .in_side   (div_side[k]),
         .in_lane0  (div_l0[k]),
         .in_lane1  (div_l1[k]),
         .out_valid (div_v[k+1]),
         .out_side  (div_side[k+1]),
         .out_lane0 (div_l0[k+1]),
         .out_lane1 (div_l1[k+1])
      );
   end

   ptc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_v[NDIV]),
      .in_side   (div_side[NDIV]),
      .in_lane0  (div_l0[NDIV]),
      .in_lane1  (div_l1[NDIV]),
      .out_valid (back_v),
      .out_res   (back_res)
   );

   assign out_take = out_v_ff && rsp_tready;
   assign push     = en && back_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (skid_v_ff) begin
            // refill the output beat from the skid entry
            if (out_take) begin
               skid_v_ff <= 1'b0;
            end
         end else if (push) begin
            if (!out_v_ff || out_take) begin
               out_v_ff <= 1'b1;
            end else begin
               skid_v_ff <= 1'b1;
            end
         end else if (out_take) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (!out_v_ff || out_take) begin
            out_ff <= back_res;
         end else begin
            skid_ff <= back_res;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_ff.dist_sq, out_ff.near[2], out_ff.near[1], out_ff.near[0]};
   assign rsp_tuser  = {out_ff.bad, out_ff.code};

endmodule

/* rtl/core/ptc_checker.sv */
module ptc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [119:0] rsp_tdata,
   input logic [3:0]   rsp_tuser
);

   // reset empties the output side
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp beat valid after reset");

   // skid entry only fills behind a waiting output beat
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req not ready with empty output");

   // zero divisor always reports vertex a
   a_degen_vertex: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> rsp_tuser[2:0] == ptc_pkg::FEAT_VERT_A)
      else $error("degenerate beat without vertex a code");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp beat changed");

endmodule

bind point_triangle_closest_point ptc_checker u_ptc_checker (.*);
